// ===== hw/rtl/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the transposition table
// Hash constants, command and bound codes, and the item record that travels
// from the hash front end through the queue to the table back end.
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam logic [63:0] HASH_MUL_A   = 64'h9E37_79B1_85EB_CA87;
    localparam logic [63:0] HASH_MUL_B   = 64'hC2B2_AE3D_27D4_EB4F;
    localparam int unsigned HASH_SHIFT_A = 23;
    localparam int unsigned HASH_SHIFT_B = 17;

    localparam logic CMD_PROBE = 1'b0;
    localparam logic CMD_STORE = 1'b1;

    localparam logic [1:0] BOUND_EXACT = 2'd0;
    localparam logic [1:0] BOUND_LOWER = 2'd1;
    localparam logic [1:0] BOUND_UPPER = 2'd2;

    localparam logic signed [3:0] NO_MOVE = -4'sd1;

    localparam int unsigned DATA_BITS  = 44;
    localparam int unsigned KEY_BITS   = 64;
    localparam int unsigned WORD_BITS  = KEY_BITS + DATA_BITS;

    localparam int unsigned QUEUE_DEPTH = 2;

    typedef struct packed {
        logic               cmd;
        logic [63:0]        key;
        logic [2:0]         partition;
        logic [5:0]         search_depth;
        logic signed [31:0] window_low;
        logic signed [31:0] window_high;
        logic signed [31:0] store_value;
        logic [1:0]         store_bound;
        logic signed [3:0]  store_move;
    } stt_item_t;

endpackage

// ===== hw/rtl/stt_req_if.sv =====
// ----------------------------------------------------------------------------
// stt_req_if: request channel of the transposition table
// Carries one probe or store command per transfer.
// ----------------------------------------------------------------------------
interface stt_req_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [63:0]        own_stones;
    logic [63:0]        occupied;
    logic [2:0]         partition;
    logic [5:0]         search_depth;
    logic signed [31:0] window_low;
    logic signed [31:0] window_high;
    logic signed [31:0] store_value;
    logic [1:0]         store_bound;
    logic signed [3:0]  store_move;

    modport source (
        output valid, cmd, own_stones, occupied, partition, search_depth,
               window_low, window_high, store_value, store_bound, store_move,
        input  ready
    );

    modport sink (
        input  valid, cmd, own_stones, occupied, partition, search_depth,
               window_low, window_high, store_value, store_bound, store_move,
        output ready
    );
endinterface

// ===== hw/rtl/stt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// stt_rsp_if: response channel of the transposition table
// Carries one result per transfer.
// ----------------------------------------------------------------------------
interface stt_rsp_if;
    logic               valid;
    logic               ready;
    logic               hint_valid;
    logic               cutoff;
    logic signed [31:0] found_value;
    logic signed [3:0]  found_move;
    logic               written;

    modport source (
        output valid, hint_valid, cutoff, found_value, found_move, written,
        input  ready
    );

    modport sink (
        input  valid, hint_valid, cutoff, found_value, found_move, written,
        output ready
    );
endinterface

// ===== hw/rtl/search_transposition_table.sv =====
// Requests pass the hash stages, the queue and the table read to the result.
// Throughput: one probe or store per cycle while results are taken, set by the
// table's separate read and write ports, with write-to-read forwarding.
// Reset: control state clears at once; then a clearing pass zeroes the table,
// one entry per cycle over all 2**INDEX_BITS entries (65536 by default), with
// req.ready held low.
// ----------------------------------------------------------------------------
// search_transposition_table: direct-mapped, depth-preferred table
// Hash front end, item queue and table back end for probes and stores.
// ----------------------------------------------------------------------------
module search_transposition_table
    import stt_pkg::*;
#(
    parameter int unsigned INDEX_BITS     = 16,
    parameter int unsigned PARTITION_BITS = 3
)
(
    input  logic       clk,
    input  logic       rst_n,
    stt_req_if.sink    req,
    stt_rsp_if.source  rsp
);

    logic      push_valid, push_ready;
    stt_item_t push_item, head_item;
    logic      q_empty, pop, clearing;

    stt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .enable     (!clearing),
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    stt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop        (pop),
        .empty      (q_empty),
        .head_item  (head_item)
    );

    stt_back #(
        .INDEX_BITS     (INDEX_BITS),
        .PARTITION_BITS (PARTITION_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .head_item (head_item),
        .pop       (pop),
        .clearing  (clearing),
        .rsp       (rsp)
    );

    a_no_transfer_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n) clearing |-> !req.ready
    ) else $error("request accepted during the clearing pass");

    a_queue_empty_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n) clearing |-> (q_empty && !push_valid)
    ) else $error("items in flight during the clearing pass");

    a_store_result_clean: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.written) |-> (!rsp.hint_valid && !rsp.cutoff)
    ) else $error("store result carries probe fields");

    a_cutoff_needs_hint: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.cutoff) |-> rsp.hint_valid
    ) else $error("cutoff without a hit");

endmodule

// ===== hw/rtl/stt_front.sv =====
// ----------------------------------------------------------------------------
// stt_front: request intake and key hashing
// Two-stage pipeline: 32x32 partial products, then the 64-bit sums and the
// xor-shift mix. Finished items are pushed into the queue.
// ----------------------------------------------------------------------------
module stt_front
    import stt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        enable,
    stt_req_if.sink     req,
    output logic        push_valid,
    input  logic        push_ready,
    output stt_item_t   push_item
);

    logic        s1_valid_reg, s1_valid_next;
    logic        s2_valid_reg, s2_valid_next;
    stt_item_t   s1_item_reg, s1_item_next;
    stt_item_t   s2_item_reg, s2_item_next;
    logic [63:0] pa_ll_reg, pa_ll_next, pb_ll_reg, pb_ll_next;
    logic [31:0] pa_hl_reg, pa_hl_next, pa_lh_reg, pa_lh_next;
    logic [31:0] pb_hl_reg, pb_hl_next, pb_lh_reg, pb_lh_next;
    logic        s1_load, s2_load, accept;
    logic [63:0] mix_a, mix_b, mix_a2, mix_b2;

    assign s2_load    = !s2_valid_reg || push_ready;
    assign s1_load    = !s1_valid_reg || s2_load;
    assign req.ready  = s1_load && enable;
    assign accept     = req.valid && req.ready;
    assign push_valid = s2_valid_reg;
    assign push_item  = s2_item_reg;

    always_comb
    begin
        s1_valid_next = s1_load ? accept : s1_valid_reg;
        s2_valid_next = s2_load ? s1_valid_reg : s2_valid_reg;

        s1_item_next              = s1_item_reg;
        pa_ll_next                = pa_ll_reg;
        pa_hl_next                = pa_hl_reg;
        pa_lh_next                = pa_lh_reg;
        pb_ll_next                = pb_ll_reg;
        pb_hl_next                = pb_hl_reg;
        pb_lh_next                = pb_lh_reg;
        if (accept)
        begin
            s1_item_next.cmd          = req.cmd;
            s1_item_next.key          = '0;
            s1_item_next.partition    = req.partition;
            s1_item_next.search_depth = req.search_depth;
            s1_item_next.window_low   = req.window_low;
            s1_item_next.window_high  = req.window_high;
            s1_item_next.store_value  = req.store_value;
            s1_item_next.store_bound  = req.store_bound;
            s1_item_next.store_move   = req.store_move;
            pa_ll_next = req.own_stones[31:0] * HASH_MUL_A[31:0];
            pa_hl_next = req.own_stones[63:32] * HASH_MUL_A[31:0];
            pa_lh_next = req.own_stones[31:0] * HASH_MUL_A[63:32];
            pb_ll_next = req.occupied[31:0] * HASH_MUL_B[31:0];
            pb_hl_next = req.occupied[63:32] * HASH_MUL_B[31:0];
            pb_lh_next = req.occupied[31:0] * HASH_MUL_B[63:32];
        end

        mix_a  = pa_ll_reg + {pa_hl_reg + pa_lh_reg, 32'h0};
        mix_b  = pb_ll_reg + {pb_hl_reg + pb_lh_reg, 32'h0};
        mix_a2 = mix_a ^ (mix_b >> HASH_SHIFT_A);
        mix_b2 = mix_b ^ (mix_a2 << HASH_SHIFT_B);

        s2_item_next = s2_item_reg;
        if (s2_load && s1_valid_reg)
        begin
            s2_item_next     = s1_item_reg;
            s2_item_next.key = mix_a2 ^ mix_b2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg <= s1_item_next;
        s2_item_reg <= s2_item_next;
        pa_ll_reg   <= pa_ll_next;
        pa_hl_reg   <= pa_hl_next;
        pa_lh_reg   <= pa_lh_next;
        pb_ll_reg   <= pb_ll_next;
        pb_hl_reg   <= pb_hl_next;
        pb_lh_reg   <= pb_lh_next;
    end

endmodule

// ===== hw/rtl/stt_queue.sv =====
// ----------------------------------------------------------------------------
// stt_queue: item queue between hash front end and table back end
// Small circular buffer that lets either side stall on its own.
// ----------------------------------------------------------------------------
module stt_queue
    import stt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  stt_item_t push_item,
    input  logic      pop,
    output logic      empty,
    output stt_item_t head_item
);

    localparam int unsigned PtrBits = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    stt_item_t            slots_reg [QUEUE_DEPTH];
    logic [PtrBits-1:0]   wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [PtrBits:0]     count_reg, count_next;
    logic                 push;

    assign push_ready = (count_reg != (PtrBits + 1)'(QUEUE_DEPTH));
    assign empty      = (count_reg == '0);
    assign push       = push_valid && push_ready;
    assign head_item  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hw/rtl/stt_back.sv =====
// ----------------------------------------------------------------------------
// stt_back: table memory, probe and store evaluation, result register
// Reads the entry when an item leaves the queue, decides once the output is
// free, writes back on a store and loads the result register. A write in
// the same cycle to the slot being read is forwarded. After reset a
// clearing pass zeroes every entry.
// ----------------------------------------------------------------------------
module stt_back
    import stt_pkg::*;
#(
    parameter int unsigned INDEX_BITS     = 16,
    parameter int unsigned PARTITION_BITS = 3
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  stt_item_t  head_item,
    output logic       pop,
    output logic       clearing,
    stt_rsp_if.source  rsp
);

    localparam int unsigned Depth = 1 << INDEX_BITS;
    localparam logic [INDEX_BITS-1:0] PartMask = INDEX_BITS'((1 << PARTITION_BITS) - 1);

    logic [WORD_BITS-1:0]  table_mem [Depth];
    logic [WORD_BITS-1:0]  rd_word_reg;
    logic                  clearing_reg, clearing_next;
    logic [INDEX_BITS-1:0] clr_addr_reg, clr_addr_next;
    logic                  cur_valid_reg, cur_valid_next;
    stt_item_t             cur_item_reg;
    logic [INDEX_BITS-1:0] cur_slot_reg, head_slot;

    logic                  out_valid_reg, out_valid_next;
    logic                  hint_valid_reg, hint_valid_next;
    logic                  cutoff_reg, cutoff_next;
    logic signed [31:0]    found_value_reg, found_value_next;
    logic signed [3:0]     found_move_reg, found_move_next;
    logic                  written_reg, written_next;

    logic                  out_can_load, finish;
    logic                  wr_en;
    logic [INDEX_BITS-1:0] wr_addr;
    logic [WORD_BITS-1:0]  wr_word;
    logic [63:0]           s_key;
    logic signed [31:0]    s_value, alpha, beta;
    logic [5:0]            s_depth;
    logic [1:0]            s_bound;
    logic signed [3:0]     s_move;
    logic                  same, hit, cut, do_write;

    assign clearing     = clearing_reg;
    assign out_can_load = !out_valid_reg || rsp.ready;
    assign finish       = cur_valid_reg && out_can_load;
    assign pop          = !clearing_reg && !q_empty && (!cur_valid_reg || finish);
    assign head_slot    = (head_item.key[INDEX_BITS-1:0] & ~PartMask)
                        | (INDEX_BITS'(head_item.partition) & PartMask);

    assign rsp.valid       = out_valid_reg;
    assign rsp.hint_valid  = hint_valid_reg;
    assign rsp.cutoff      = cutoff_reg;
    assign rsp.found_value = found_value_reg;
    assign rsp.found_move  = found_move_reg;
    assign rsp.written     = written_reg;

    always_comb
    begin
        s_key   = rd_word_reg[WORD_BITS-1:DATA_BITS];
        s_value = rd_word_reg[31:0];
        s_depth = rd_word_reg[37:32];
        s_bound = rd_word_reg[39:38];
        s_move  = rd_word_reg[43:40];
        same    = (s_key == cur_item_reg.key);
        hit     = same && (s_depth >= cur_item_reg.search_depth);

        alpha = cur_item_reg.window_low;
        beta  = cur_item_reg.window_high;
        if ((s_bound == BOUND_LOWER) && (s_value > alpha))
        begin
            alpha = s_value;
        end
        if ((s_bound == BOUND_UPPER) && (s_value < beta))
        begin
            beta = s_value;
        end
        cut      = (s_bound == BOUND_EXACT) || (alpha >= beta);
        do_write = !(same && (s_depth > cur_item_reg.search_depth));

        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == '1)
            begin
                clearing_next = 1'b0;
            end
        end

        wr_en   = clearing_reg || (finish && (cur_item_reg.cmd == CMD_STORE) && do_write);
        wr_addr = clearing_reg ? clr_addr_reg : cur_slot_reg;
        wr_word = clearing_reg ? '0 : {cur_item_reg.key, cur_item_reg.store_move,
                                       cur_item_reg.store_bound, cur_item_reg.search_depth,
                                       cur_item_reg.store_value};

        if (pop)
        begin
            cur_valid_next = 1'b1;
        end
        else if (finish)
        begin
            cur_valid_next = 1'b0;
        end
        else
        begin
            cur_valid_next = cur_valid_reg;
        end

        out_valid_next   = out_can_load ? finish : out_valid_reg;
        hint_valid_next  = hint_valid_reg;
        cutoff_next      = cutoff_reg;
        found_value_next = found_value_reg;
        found_move_next  = found_move_reg;
        written_next     = written_reg;
        if (finish)
        begin
            if (cur_item_reg.cmd == CMD_PROBE)
            begin
                hint_valid_next  = hit;
                cutoff_next      = hit && cut;
                found_value_next = hit ? s_value : '0;
                found_move_next  = hit ? s_move : NO_MOVE;
                written_next     = 1'b0;
            end
            else
            begin
                hint_valid_next  = 1'b0;
                cutoff_next      = 1'b0;
                found_value_next = '0;
                found_move_next  = NO_MOVE;
                written_next     = do_write;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clearing_reg  <= clearing_next;
            clr_addr_reg  <= clr_addr_next;
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_word;
        end
        if (pop)
        begin
            rd_word_reg  <= (wr_en && (wr_addr == head_slot)) ? wr_word : table_mem[head_slot];
            cur_item_reg <= head_item;
            cur_slot_reg <= head_slot;
        end
    end

    always_ff @(posedge clk)
    begin
        hint_valid_reg  <= hint_valid_next;
        cutoff_reg      <= cutoff_next;
        found_value_reg <= found_value_next;
        found_move_reg  <= found_move_next;
        written_reg     <= written_next;
    end

endmodule

// ===== sim/search_transposition_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// search_transposition_table_tb: self-checking bench for the transposition table
// Sends directed and random probes and stores to the block. A behavioral copy
// of the table predicts every result, and each result is compared with that
// prediction field by field. Both channels idle at random, and the result side
// holds off once for a long time.
// ----------------------------------------------------------------------------
module search_transposition_table_tb;
    import stt_pkg::*;

    localparam int unsigned INDEX_BITS     = 16;
    localparam int unsigned PARTITION_BITS = 3;
    localparam int unsigned TABLE_SLOTS    = 1 << INDEX_BITS;
    localparam int unsigned RANDOM_ITEMS   = 400;
    localparam int unsigned QUIET_ITEMS    = 60;
    localparam int unsigned PRESSURE_AT    = 150;
    localparam int unsigned PRESSURE_ITEMS = 24;
    localparam int unsigned HOLD_CYCLES    = 80;
    localparam int unsigned DRAIN_CYCLES   = 12;
    localparam int unsigned STALL_LIMIT    = 200000;
    localparam int          SCORE_LIMIT    = 2000000000;

    localparam logic [1:0] BOUND_INVALID = 2'd3;

    typedef struct {
        logic               cmd;
        logic [63:0]        own_stones;
        logic [63:0]        occupied;
        logic [2:0]         partition;
        logic [5:0]         search_depth;
        logic signed [31:0] window_low;
        logic signed [31:0] window_high;
        logic signed [31:0] store_value;
        logic [1:0]         store_bound;
        logic signed [3:0]  store_move;
    } tt_request_t;

    typedef struct {
        logic               hint_valid;
        logic               cutoff;
        logic signed [31:0] found_value;
        logic signed [3:0]  found_move;
        logic               written;
    } tt_result_t;

    typedef struct {
        logic [63:0] own;
        logic [63:0] occ;
        logic [2:0]  part;
    } position_t;

    class table_scoreboard;
        logic [63:0] slot_key  [TABLE_SLOTS];
        logic [43:0] slot_data [TABLE_SLOTS];
        tt_result_t  due_results[$];
        int unsigned errors;

        function new();
            foreach (slot_key[i])
            begin
                slot_key[i]  = '0;
                slot_data[i] = '0;
            end
            errors = 0;
        endfunction

        function logic [63:0] position_key(logic [63:0] own, logic [63:0] occ);
            logic [63:0] a;
            logic [63:0] b;
            a = own * HASH_MUL_A;
            b = occ * HASH_MUL_B;
            a = a ^ (b >> HASH_SHIFT_A);
            b = b ^ (a << HASH_SHIFT_B);
            return a ^ b;
        endfunction

        function int unsigned slot_index(logic [63:0] key, logic [2:0] part);
            logic [INDEX_BITS-1:0] idx;
            idx = key[INDEX_BITS-1:0];
            idx[PARTITION_BITS-1:0] = part[PARTITION_BITS-1:0];
            return idx;
        endfunction

        function void note_request(tt_request_t r);
            logic [63:0]        key;
            int unsigned        slot;
            logic [43:0]        entry;
            logic [5:0]         kept_depth;
            logic [1:0]         kept_bound;
            logic signed [31:0] kept_value;
            logic signed [31:0] alpha;
            logic signed [31:0] beta;
            logic               same;
            tt_result_t         res;
            key        = position_key(r.own_stones, r.occupied);
            slot       = slot_index(key, r.partition);
            entry      = slot_data[slot];
            kept_value = entry[31:0];
            kept_depth = entry[37:32];
            kept_bound = entry[39:38];
            same       = (slot_key[slot] == key);
            res.hint_valid  = 1'b0;
            res.cutoff      = 1'b0;
            res.found_value = '0;
            res.found_move  = NO_MOVE;
            res.written     = 1'b0;
            if (r.cmd == CMD_PROBE)
            begin
                if (same && kept_depth >= r.search_depth)
                begin
                    res.hint_valid  = 1'b1;
                    res.found_value = kept_value;
                    res.found_move  = entry[43:40];
                    alpha = r.window_low;
                    beta  = r.window_high;
                    if (kept_bound == BOUND_LOWER && kept_value > alpha)
                        alpha = kept_value;
                    if (kept_bound == BOUND_UPPER && kept_value < beta)
                        beta = kept_value;
                    res.cutoff = (kept_bound == BOUND_EXACT) || (alpha >= beta);
                end
            end
            else if (!(same && kept_depth > r.search_depth))
            begin
                slot_key[slot]  = key;
                slot_data[slot] = {r.store_move, r.store_bound, r.search_depth,
                                   r.store_value};
                res.written = 1'b1;
            end
            due_results.push_back(res);
        endfunction

        function void compare_field(string field, logic signed [63:0] want,
                                    logic signed [63:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(tt_result_t got);
            tt_result_t want;
            if (due_results.size() == 0)
            begin
                $error("result transfer with no request outstanding");
                errors++;
                return;
            end
            want = due_results.pop_front();
            compare_field("hint_valid", want.hint_valid, got.hint_valid);
            compare_field("cutoff", want.cutoff, got.cutoff);
            compare_field("found_value", want.found_value, got.found_value);
            compare_field("found_move", want.found_move, got.found_move);
            compare_field("written", want.written, got.written);
        endfunction

        function int unsigned pending();
            return due_results.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    stt_req_if req_ch();
    stt_rsp_if rsp_ch();

    table_scoreboard table_sb;
    position_t       spots[$];
    bit              hold_wanted = 1'b0;
    bit              holding = 1'b0;
    bit              quiet = 1'b0;
    int unsigned     stall_cycles = 0;

    search_transposition_table u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    function automatic logic [63:0] random_board();
        return {$urandom, $urandom};
    endfunction

    function automatic position_t random_position();
        position_t p;
        p.own  = random_board();
        p.occ  = random_board();
        p.part = 3'($urandom_range(0, 7));
        return p;
    endfunction

    // A different position whose key lands in the same slot as the given one.
    function automatic position_t slot_rival(position_t p);
        position_t   q;
        logic [63:0] kp;
        logic [63:0] kq;
        kp = table_sb.position_key(p.own, p.occ);
        do
        begin
            q  = random_position();
            kq = table_sb.position_key(q.own, q.occ);
        end
        while (kq[INDEX_BITS-1:PARTITION_BITS] != kp[INDEX_BITS-1:PARTITION_BITS]
               || kq == kp);
        q.part = p.part;
        return q;
    endfunction

    function automatic tt_request_t make_item(logic cmd, position_t p, int depth,
                                              int wlo, int whi, int val,
                                              logic [1:0] bound, int move);
        tt_request_t r;
        r.cmd          = cmd;
        r.own_stones   = p.own;
        r.occupied     = p.occ;
        r.partition    = p.part;
        r.search_depth = 6'(depth);
        r.window_low   = wlo;
        r.window_high  = whi;
        r.store_value  = val;
        r.store_bound  = bound;
        r.store_move   = 4'(move);
        return r;
    endfunction

    function automatic int random_score();
        case ($urandom_range(0, 3))
            0: return ($urandom_range(0, 1) != 0) ? SCORE_LIMIT : -SCORE_LIMIT;
            1: return int'($urandom_range(0, 40)) - 20;
            default: return int'($urandom_range(0, 32'd4000000000) - 32'd2000000000);
        endcase
    endfunction

    function automatic tt_request_t random_request();
        position_t  p;
        logic       cmd;
        int         depth;
        logic [1:0] bound;
        if ($urandom_range(0, 9) < 8)
        begin
            p = spots[$urandom_range(0, spots.size() - 1)];
            if ($urandom_range(0, 15) == 0)
                p.part = 3'($urandom_range(0, 7));
        end
        else
            p = random_position();
        cmd   = ($urandom_range(0, 9) < 4) ? CMD_STORE : CMD_PROBE;
        depth = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 12);
        bound = ($urandom_range(0, 9) == 0) ? BOUND_INVALID
                                            : 2'($urandom_range(BOUND_EXACT, BOUND_UPPER));
        return make_item(cmd, p, depth, random_score(), random_score(), random_score(),
                         bound, int'($urandom_range(0, 7)) - 1);
    endfunction

    task automatic offer(input tt_request_t r, input bit gaps);
        if (gaps && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.cmd          <= r.cmd;
        req_ch.own_stones   <= r.own_stones;
        req_ch.occupied     <= r.occupied;
        req_ch.partition    <= r.partition;
        req_ch.search_depth <= r.search_depth;
        req_ch.window_low   <= r.window_low;
        req_ch.window_high  <= r.window_high;
        req_ch.store_value  <= r.store_value;
        req_ch.store_bound  <= r.store_bound;
        req_ch.store_move   <= r.store_move;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
    endtask

    initial
    begin : result_ready
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_wanted)
            begin
                rsp_ch.ready <= 1'b0;
                holding = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_wanted = 1'b0;
                holding = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : transfer_monitor
        tt_request_t seen;
        tt_result_t  got;
        logic        moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                seen.cmd          = req_ch.cmd;
                seen.own_stones   = req_ch.own_stones;
                seen.occupied     = req_ch.occupied;
                seen.partition    = req_ch.partition;
                seen.search_depth = req_ch.search_depth;
                seen.window_low   = req_ch.window_low;
                seen.window_high  = req_ch.window_high;
                seen.store_value  = req_ch.store_value;
                seen.store_bound  = req_ch.store_bound;
                seen.store_move   = req_ch.store_move;
                table_sb.note_request(seen);
                moved = 1'b1;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.hint_valid  = rsp_ch.hint_valid;
                got.cutoff      = rsp_ch.cutoff;
                got.found_value = rsp_ch.found_value;
                got.found_move  = rsp_ch.found_move;
                got.written     = rsp_ch.written;
                table_sb.check_result(got);
                moved = 1'b1;
            end
        end
        stall_cycles = moved ? 0 : stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT)
        begin
            $display("search_transposition_table: mismatch");
            $finish;
        end
    end

    initial
    begin : stimulus
        position_t   zero_pos;
        position_t   full_pos;
        position_t   p0;
        position_t   c0;
        position_t   p1;
        position_t   p1_moved;
        int unsigned i;
        int unsigned k;
        table_sb = new();
        req_ch.valid        <= 1'b0;
        req_ch.cmd          <= CMD_PROBE;
        req_ch.own_stones   <= '0;
        req_ch.occupied     <= '0;
        req_ch.partition    <= '0;
        req_ch.search_depth <= '0;
        req_ch.window_low   <= '0;
        req_ch.window_high  <= '0;
        req_ch.store_value  <= '0;
        req_ch.store_bound  <= BOUND_EXACT;
        req_ch.store_move   <= NO_MOVE;

        zero_pos.own  = '0;
        zero_pos.occ  = '0;
        zero_pos.part = 3'd0;
        full_pos.own  = '1;
        full_pos.occ  = '1;
        full_pos.part = 3'd7;
        p0      = random_position();
        p0.part = 3'd5;
        c0      = slot_rival(p0);
        p1      = random_position();
        p1.part = 3'd3;
        p1_moved      = p1;
        p1_moved.part = 3'd4;
        spots.push_back(zero_pos);
        spots.push_back(p0);
        spots.push_back(c0);
        spots.push_back(p1);
        for (k = 0; k < 16; k++)
            spots.push_back(random_position());
        for (k = 0; k < 3; k++)
            spots.push_back(slot_rival(spots[4 + k]));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The empty board hashes to key zero and so matches a cleared entry.
        offer(make_item(CMD_PROBE, zero_pos, 0, -SCORE_LIMIT, SCORE_LIMIT, 0,
                        BOUND_EXACT, NO_MOVE), 1'b1);
        offer(make_item(CMD_PROBE, zero_pos, 1, -SCORE_LIMIT, SCORE_LIMIT, 0,
                        BOUND_EXACT, NO_MOVE), 1'b1);
        offer(make_item(CMD_PROBE, full_pos, 63, SCORE_LIMIT, -SCORE_LIMIT, 0,
                        BOUND_EXACT, NO_MOVE), 1'b1);
        offer(make_item(CMD_STORE, p0, 10, 0, 0, SCORE_LIMIT, BOUND_EXACT, 6), 1'b1);
        offer(make_item(CMD_PROBE, p0, 10, 0, 0, 0, BOUND_EXACT, 0), 1'b1);
        offer(make_item(CMD_PROBE, p0, 11, 0, 0, 0, BOUND_EXACT, 0), 1'b1);
        offer(make_item(CMD_STORE, p0, 5, 0, 0, -1, BOUND_LOWER, 0), 1'b1);
        offer(make_item(CMD_STORE, p0, 10, 0, 0, -SCORE_LIMIT, BOUND_LOWER, NO_MOVE),
              1'b1);
        offer(make_item(CMD_PROBE, p0, 0, -SCORE_LIMIT, SCORE_LIMIT, 0, BOUND_EXACT, 0),
              1'b1);
        offer(make_item(CMD_PROBE, p0, 3, 0, 0, 0, BOUND_EXACT, 0), 1'b1);
        offer(make_item(CMD_STORE, p0, 20, 0, 0, 100, BOUND_UPPER, 3), 1'b1);
        offer(make_item(CMD_PROBE, p0, 20, 50, 200, 0, BOUND_EXACT, 0), 1'b1);
        offer(make_item(CMD_PROBE, p0, 20, 150, 200, 0, BOUND_EXACT, 0), 1'b1);
        offer(make_item(CMD_PROBE, p0, 1, 200, 100, 0, BOUND_EXACT, 0), 1'b1);
        offer(make_item(CMD_STORE, p0, 20, 0, 0, 7, BOUND_INVALID, 2), 1'b1);
        offer(make_item(CMD_PROBE, p0, 20, 0, 10, 0, BOUND_EXACT, 0), 1'b1);
        offer(make_item(CMD_PROBE, p0, 20, 10, 10, 0, BOUND_EXACT, 0), 1'b1);
        offer(make_item(CMD_STORE, c0, 0, 0, 0, -5, BOUND_EXACT, 1), 1'b1);
        offer(make_item(CMD_PROBE, p0, 0, 0, 0, 0, BOUND_EXACT, 0), 1'b1);
        offer(make_item(CMD_PROBE, c0, 0, 0, 0, 0, BOUND_EXACT, 0), 1'b1);
        offer(make_item(CMD_STORE, p1, 63, 0, 0, SCORE_LIMIT, BOUND_LOWER, 5), 1'b1);
        offer(make_item(CMD_PROBE, p1_moved, 63, -SCORE_LIMIT, SCORE_LIMIT, 0,
                        BOUND_EXACT, 0), 1'b1);
        offer(make_item(CMD_PROBE, p1, 63, -SCORE_LIMIT, SCORE_LIMIT, 0,
                        BOUND_EXACT, 0), 1'b1);
        offer(make_item(CMD_STORE, zero_pos, 2, 0, 0, -SCORE_LIMIT, BOUND_UPPER, 4),
              1'b1);
        offer(make_item(CMD_PROBE, zero_pos, 2, -SCORE_LIMIT, SCORE_LIMIT, 0,
                        BOUND_EXACT, 0), 1'b1);

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == PRESSURE_AT)
            begin
                // Keep offering while results back up, so the block must stall
                // its request side until the hold-off ends.
                hold_wanted = 1'b1;
                req_ch.valid <= 1'b0;
                wait (holding);
                @(posedge clk);
                for (k = 0; k < PRESSURE_ITEMS; k++)
                    offer(random_request(), 1'b0);
            end
            if (i == RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            offer(random_request(), !quiet);
        end
        req_ch.valid <= 1'b0;

        while (table_sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (table_sb.errors == 0)
            $display("search_transposition_table: match");
        else
            $display("search_transposition_table: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/stt_pkg.sv
hw/rtl/stt_req_if.sv
hw/rtl/stt_rsp_if.sv
hw/rtl/stt_front.sv
hw/rtl/stt_queue.sv
hw/rtl/stt_back.sv
hw/rtl/search_transposition_table.sv
sim/search_transposition_table_tb.sv
